// ===== src/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency package
// Shared command and status codes and the edge match result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tea_pkg;

  // Number of corners, and so of edges, of one triangle.
  localparam int unsigned Edges = 3;

  // Width of the triangle index fields on the ports.
  localparam int unsigned IdFieldBits = 8;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_LOADED = 2'd1,
    ST_FULL       = 2'd2
  } status_e;

  // Result of comparing the edges of one stored triangle with the new one.
  typedef struct packed {
    logic [Edges-1:0] old_hit;  // stored edge is open and matches a new edge
    logic [Edges-1:0] new_hit;  // new edge matches an open stored edge
  } match_t;

endpackage

// ===== src/tea_in_if.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency input channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tea_in_if #(
  parameter int unsigned VERTEX_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             command;
  logic [VERTEX_BITS-1:0] vertex_a;
  logic [VERTEX_BITS-1:0] vertex_b;
  logic [VERTEX_BITS-1:0] vertex_c;
  logic [7:0]             query_index;

  modport source (
    output valid, command, vertex_a, vertex_b, vertex_c, query_index,
    input  ready
  );

  modport sink (
    input  valid, command, vertex_a, vertex_b, vertex_c, query_index,
    output ready
  );
endinterface

// ===== src/tea_out_if.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tea_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] triangle_id;
  logic [7:0] neighbor_0;
  logic [7:0] neighbor_1;
  logic [7:0] neighbor_2;
  logic       has_neighbor_0;
  logic       has_neighbor_1;
  logic       has_neighbor_2;

  modport source (
    output valid, status, triangle_id, neighbor_0, neighbor_1, neighbor_2,
           has_neighbor_0, has_neighbor_1, has_neighbor_2,
    input  ready
  );

  modport sink (
    input  valid, status, triangle_id, neighbor_0, neighbor_1, neighbor_2,
           has_neighbor_0, has_neighbor_1, has_neighbor_2,
    output ready
  );
endinterface

// ===== src/tea_edge_match.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency edge matcher
// Compares the open edges of one stored triangle with the new triangle's
// edges as unordered vertex pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tea_edge_match #(
  parameter int unsigned VERTEX_BITS = 16
) (
  input  logic [2:0][VERTEX_BITS-1:0] old_corner_i,
  input  logic [2:0]                  old_open_i,
  input  logic [2:0][VERTEX_BITS-1:0] new_corner_i,
  output tea_pkg::match_t             match_o
);
  import tea_pkg::*;

  logic [Edges-1:0][VERTEX_BITS-1:0] old_lo, old_hi, new_lo, new_hi;
  logic [Edges-1:0][Edges-1:0]       hit;  // [stored edge][new edge]

  // Put each edge into canonical order, smaller vertex first.
  always_comb begin
    for (int e = 0; e < Edges; e++) begin
      if (old_corner_i[e] < old_corner_i[(e + 1) % Edges]) begin
        old_lo[e] = old_corner_i[e];
        old_hi[e] = old_corner_i[(e + 1) % Edges];
      end else begin
        old_lo[e] = old_corner_i[(e + 1) % Edges];
        old_hi[e] = old_corner_i[e];
      end
      if (new_corner_i[e] < new_corner_i[(e + 1) % Edges]) begin
        new_lo[e] = new_corner_i[e];
        new_hi[e] = new_corner_i[(e + 1) % Edges];
      end else begin
        new_lo[e] = new_corner_i[(e + 1) % Edges];
        new_hi[e] = new_corner_i[e];
      end
    end
  end

  always_comb begin
    for (int o = 0; o < Edges; o++) begin
      for (int n = 0; n < Edges; n++) begin
        hit[o][n] = old_open_i[o] && (old_lo[o] == new_lo[n]) && (old_hi[o] == new_hi[n]);
      end
    end
    for (int e = 0; e < Edges; e++) begin
      match_o.old_hit[e] = |hit[e];
      match_o.new_hit[e] = hit[0][e] | hit[1][e] | hit[2][e];
    end
  end

endmodule

// ===== src/triangle_edge_adjacency.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency
// Sequence: a load scans any stored rows, then passes S_LAST and S_EMIT; a query
// of a loaded row passes S_QRD and S_EMIT; all other items go straight to S_EMIT.
// Throughput: one item at a time; a load is bound by the stored-row scan, one
// row per cycle through the single read port of the triangle memories.
// Reset: the triangle count and handshake state clear at once; the memories
// are not cleared, and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_edge_adjacency #(
  parameter int unsigned MAX_TRIANGLES = 256,
  parameter int unsigned VERTEX_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tea_in_if.sink     in_i,
  tea_out_if.source  out_o
);
  import tea_pkg::*;

  // Triangle index width, count width (holds MAX_TRIANGLES itself), and a
  // compare width that covers both the count and the query index.
  localparam int unsigned IdxW = $clog2(MAX_TRIANGLES);
  localparam int unsigned CntW = $clog2(MAX_TRIANGLES + 1);
  localparam int unsigned CmpW = (CntW > IdFieldBits) ? CntW : IdFieldBits;
  // One link: a valid flag above the neighbor's triangle index.
  localparam int unsigned LnkW = IdxW + 1;

  typedef logic [2:0][VERTEX_BITS-1:0] corner_row_t;
  typedef logic [2:0][LnkW-1:0]        link_row_t;

  typedef struct packed {
    status_e                       status;
    logic [IdFieldBits-1:0]        id;
    logic [2:0][IdFieldBits-1:0]   nb;
    logic [2:0]                    has;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for an item
    S_SCAN = 5'b00010,  // one stored triangle compared per cycle
    S_LAST = 5'b00100,  // new triangle's links written back
    S_QRD  = 5'b01000,  // query row arriving from memory
    S_EMIT = 5'b10000   // result waits for the output register
  } state_e;

  // Turns a row of links into the neighbor fields of a result. An open edge
  // reads as neighbor zero.
  function automatic res_t links_to_res(status_e st, logic [IdFieldBits-1:0] id,
                                        link_row_t lnk);
    res_t r;
    r.status = st;
    r.id     = id;
    for (int e = 0; e < Edges; e++) begin
      r.has[e] = lnk[e][IdxW];
      r.nb[e]  = lnk[e][IdxW] ? IdFieldBits'(lnk[e][IdxW-1:0]) : '0;
    end
    return r;
  endfunction

  state_e                 state_q, state_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [IdxW-1:0]        scan_q, scan_d;
  corner_row_t            nc_q, nc_d;
  link_row_t              nl_q, nl_d;
  res_t                   res_q, res_d;
  res_t                   out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // Triangle memories: one row of three corners and one row of three links
  // per triangle. Written at one address and read at one per cycle.
  corner_row_t            corner_mem [MAX_TRIANGLES];
  link_row_t              link_mem   [MAX_TRIANGLES];
  corner_row_t            corner_rd_q;
  link_row_t              link_rd_q;

  logic                   mem_rd_en;
  logic [IdxW-1:0]        mem_rd_addr;
  logic                   corner_we;
  corner_row_t            corner_wdata;
  logic                   link_we;
  logic [IdxW-1:0]        link_waddr;
  link_row_t              link_wdata;

  logic                   accept;
  logic                   table_full;
  logic                   scan_last;
  logic [2:0]             old_open;
  match_t                 match;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign table_full = (count_q == CntW'(MAX_TRIANGLES));
  // The row now in the read register is the last stored triangle.
  assign scan_last  = ((CntW'(scan_q) + CntW'(1)) == count_q);

  // The new triangle's corners; the count names the free row.
  assign corner_wdata = {VERTEX_BITS'(in_i.vertex_c), VERTEX_BITS'(in_i.vertex_b),
                         VERTEX_BITS'(in_i.vertex_a)};

  always_comb begin
    for (int e = 0; e < Edges; e++) begin
      old_open[e] = !link_rd_q[e][IdxW];
    end
  end

  // The shared compare unit sees one stored triangle per scan cycle.
  tea_edge_match #(
    .VERTEX_BITS (VERTEX_BITS)
  ) u_match (
    .old_corner_i (corner_rd_q),
    .old_open_i   (old_open),
    .new_corner_i (nc_q),
    .match_o      (match)
  );

  // Sequencer. A load stores its corners in the accept cycle and, if rows are
  // stored, starts the read of row zero; each scan cycle then compares the row that
  // arrived, writes its links back and fetches the next row. New-edge links keep the
  // last matching triangle, which falls out of the ascending scan.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    nc_d        = nc_q;
    nl_d        = nl_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = scan_q;
    corner_we   = 1'b0;
    link_we     = 1'b0;
    link_waddr  = scan_q;
    link_wdata  = link_rd_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d = '0;
          case (cmd_e'(in_i.command))
            CMD_LOAD: begin
              if (table_full) begin
                res_d.status = ST_FULL;
                state_d      = S_EMIT;
              end else begin
                corner_we = 1'b1;
                nc_d      = corner_wdata;
                nl_d      = '0;
                if (count_q == '0) begin
                  state_d = S_LAST;
                end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = '0;
                  scan_d      = '0;
                  state_d     = S_SCAN;
                end
              end
            end
            CMD_QUERY: begin
              res_d.id = in_i.query_index;
              if (CmpW'(in_i.query_index) >= CmpW'(count_q)) begin
                res_d.status = ST_NOT_LOADED;
                state_d      = S_EMIT;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IdxW'(in_i.query_index);
                state_d     = S_QRD;
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_EMIT;
            end
            default: begin
              // Unused command: no change, all-zero result.
              state_d = S_EMIT;
            end
          endcase
        end
      end

      S_SCAN: begin
        link_we    = 1'b1;
        link_waddr = scan_q;
        for (int e = 0; e < Edges; e++) begin
          if (match.old_hit[e]) begin
            link_wdata[e] = {1'b1, count_q[IdxW-1:0]};
          end
          if (match.new_hit[e]) begin
            nl_d[e] = {1'b1, scan_q};
          end
        end
        if (scan_last) begin
          state_d = S_LAST;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = IdxW'(scan_q + 1'b1);
          scan_d      = IdxW'(scan_q + 1'b1);
        end
      end

      S_LAST: begin
        link_we    = 1'b1;
        link_waddr = count_q[IdxW-1:0];
        link_wdata = nl_q;
        res_d      = links_to_res(ST_OK, IdFieldBits'(count_q), nl_q);
        count_d    = CntW'(count_q + 1'b1);
        state_d    = S_EMIT;
      end

      S_QRD: begin
        res_d   = links_to_res(ST_OK, res_q.id, link_rd_q);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    nc_q   <= nc_d;
    nl_q   <= nl_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (corner_we) begin
      corner_mem[count_q[IdxW-1:0]] <= corner_wdata;
    end
    if (mem_rd_en) begin
      corner_rd_q <= corner_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (mem_rd_en) begin
      link_rd_q <= link_mem[mem_rd_addr];
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.triangle_id    = out_q.id;
  assign out_o.neighbor_0     = out_q.nb[0];
  assign out_o.neighbor_1     = out_q.nb[1];
  assign out_o.neighbor_2     = out_q.nb[2];
  assign out_o.has_neighbor_0 = out_q.has[0];
  assign out_o.has_neighbor_1 = out_q.has[1];
  assign out_o.has_neighbor_2 = out_q.has[2];

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Triangle edge adjacency testbench
// Sends load, query, clear and unused commands through the input channel and
// predicts every result with a behavioral copy of the triangle table. Results
// are checked field by field in arrival order, with random idle bursts on
// both channels, one long result back-pressure stretch and a table fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tea_pkg::*;

  localparam int unsigned MaxTriangles = 256;
  localparam int unsigned VertexBits   = 16;

  // The command field is two bits wide, so the one code the block does not
  // define still has to be exercised. It must be ignored but still answered.
  localparam logic [1:0] CmdUnused = 2'd3;

  // One expected result item, laid out like the result channel.
  typedef struct packed {
    status_e          status;
    logic [7:0]       tri_id;
    logic [2:0][7:0]  nbr;
    logic [2:0]       has_nbr;
  } adj_result_t;

  logic clk_i;
  logic rst_ni;

  tea_in_if #(.VERTEX_BITS(VertexBits)) in_if ();
  tea_out_if                            out_if ();

  triangle_edge_adjacency #(
    .MAX_TRIANGLES(MaxTriangles),
    .VERTEX_BITS  (VertexBits)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Behavioral copy of the triangle table. Corners are stored three per
  // triangle, and each edge has a link flag and the index it links to.
  logic [VertexBits-1:0] corner_mem [3*MaxTriangles];
  bit                    link_ok    [3*MaxTriangles];
  logic [8:0]            link_to    [3*MaxTriangles];
  int unsigned           tri_count;

  // Expected results, oldest first.
  adj_result_t pending_adjacency [$];

  int unsigned     failures;
  bit              calm;          // set in the last part: no idling on either side
  int unsigned     hold_request;  // long result stall asked for by a test
  logic [15:0]     pool_base;     // base of the small vertex pool for mesh loads

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Generous bound on the whole run. A correct run stays far below it even
  // when every load scans a full table and both sides idle as much as they can.
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Edges are compared as unordered vertex pairs.
  function automatic bit same_edge(logic [15:0] p1, p2, q1, q2);
    return (p1 == q1 && p2 == q2) || (p1 == q2 && p2 == q1);
  endfunction

  // Copies the three links of one stored triangle into a result. An open
  // edge leaves its neighbor field at zero.
  function automatic void fill_links(int unsigned t, inout adj_result_t r);
    for (int e = 0; e < Edges; e++) begin
      if (link_ok[3*t+e]) begin
        r.nbr[e]     = link_to[3*t+e][7:0];
        r.has_nbr[e] = 1'b1;
      end
    end
  endfunction

  // Applies one accepted item to the table copy and queues its result.
  function automatic void predict_adjacency(logic [1:0] cmd, logic [15:0] va, vb, vc,
                                            logic [7:0] qi);
    adj_result_t r;
    int unsigned n;
    logic [15:0] p1, p2, q1, q2;
    r        = '0;
    r.status = ST_OK;
    case (cmd)
      CMD_LOAD: begin
        if (tri_count >= MaxTriangles) begin
          // The table is full, so the load is dropped and all fields stay zero.
          r.status = ST_FULL;
        end else begin
          n = tri_count;
          corner_mem[3*n]   = va;
          corner_mem[3*n+1] = vb;
          corner_mem[3*n+2] = vc;
          for (int e = 0; e < Edges; e++) link_ok[3*n+e] = 1'b0;
          // Stored triangles are visited in ascending order. Only edges that
          // are still open take part, and a new edge keeps its last match.
          for (int unsigned i = 0; i < n; i++) begin
            for (int ei = 0; ei < Edges; ei++) begin
              if (!link_ok[3*i+ei]) begin
                p1 = corner_mem[3*i+ei];
                p2 = corner_mem[3*i+(ei+1)%Edges];
                for (int en = 0; en < Edges; en++) begin
                  q1 = corner_mem[3*n+en];
                  q2 = corner_mem[3*n+(en+1)%Edges];
                  if (same_edge(p1, p2, q1, q2)) begin
                    link_ok[3*i+ei] = 1'b1;
                    link_to[3*i+ei] = n[8:0];
                    link_ok[3*n+en] = 1'b1;
                    link_to[3*n+en] = i[8:0];
                  end
                end
              end
            end
          end
          tri_count = n + 1;
          r.tri_id  = n[7:0];
          fill_links(n, r);
        end
      end
      CMD_QUERY: begin
        r.tri_id = qi;
        if (qi >= tri_count) r.status = ST_NOT_LOADED;
        else fill_links(qi, r);
      end
      CMD_CLEAR: begin
        tri_count = 0;
      end
      default: begin
        // The unused command leaves the table alone and answers with zeros.
      end
    endcase
    pending_adjacency.push_back(r);
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off and the field checks
  // --------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  // Values are read in the active region right after the edge, so they are
  // the ones the block presented at that edge.
  initial begin
    int unsigned stall_left;
    adj_result_t want;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        if (pending_adjacency.size() == 0) begin
          $error("result item with nothing expected: status %0d, triangle_id %0d",
                 out_if.status, out_if.triangle_id);
          failures++;
        end else begin
          want = pending_adjacency.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("triangle_id", want.tri_id, out_if.triangle_id);
          check_field("neighbor_0", want.nbr[0], out_if.neighbor_0);
          check_field("neighbor_1", want.nbr[1], out_if.neighbor_1);
          check_field("neighbor_2", want.nbr[2], out_if.neighbor_2);
          check_field("has_neighbor_0", want.has_nbr[0], out_if.has_neighbor_0);
          check_field("has_neighbor_1", want.has_nbr[1], out_if.has_neighbor_1);
          check_field("has_neighbor_2", want.has_nbr[2], out_if.has_neighbor_2);
        end
      end
      // A long hold-off replaces whatever burst is running.
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall_left   = $urandom_range(1, 11) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offers one item and returns in the time step of its acceptance, with
  // valid still high. The caller either offers the next item in that same
  // step or lowers valid before it waits for anything.
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] va, vb, vc,
                           input logic [7:0] qi);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.command     <= cmd;
    in_if.vertex_a    <= va;
    in_if.vertex_b    <= vb;
    in_if.vertex_c    <= vc;
    in_if.query_index <= qi;
    do @(posedge clk_i); while (!in_if.ready);
    predict_adjacency(cmd, va, vb, vc, qi);
  endtask

  task automatic send_load(input logic [15:0] va, vb, vc);
    send_item(CMD_LOAD, va, vb, vc, 8'($urandom));
  endtask

  task automatic send_query(input logic [7:0] qi);
    send_item(CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom), qi);
  endtask

  // Builds a triangle that is likely to share edges with the stored mesh.
  // Half the time it reuses an edge of a stored triangle, mostly in reverse
  // order as a consistent mesh would. Otherwise the corners come from a small
  // vertex pool, which also gives degenerate edges, or from the full range.
  task automatic pick_triangle(output logic [15:0] va, vb, vc);
    int unsigned mode, t, e;
    logic [15:0] u, v, w, tmp;
    mode = $urandom_range(0, 9);
    if (mode < 5 && tri_count > 0) begin
      t = $urandom_range(0, tri_count - 1);
      e = $urandom_range(0, Edges - 1);
      u = corner_mem[3*t+e];
      v = corner_mem[3*t+(e+1)%Edges];
      if ($urandom_range(0, 3) != 0) begin
        tmp = u;
        u   = v;
        v   = tmp;
      end
      w = pool_base + 16'($urandom_range(0, 7));
    end else if (mode < 8) begin
      u = pool_base + 16'($urandom_range(0, 7));
      v = pool_base + 16'($urandom_range(0, 7));
      w = pool_base + 16'($urandom_range(0, 7));
    end else begin
      u = 16'($urandom);
      v = 16'($urandom);
      w = 16'($urandom);
    end
    case ($urandom_range(0, 2))
      0: begin va = u; vb = v; vc = w; end
      1: begin va = v; vb = w; vc = u; end
      default: begin va = w; vb = u; vc = v; end
    endcase
  endtask

  task automatic send_mesh_load();
    logic [15:0] va, vb, vc;
    pick_triangle(va, vb, vc);
    send_load(va, vb, vc);
  endtask

  // Queries mostly hit loaded triangles; the rest may ask for any index.
  task automatic send_random_query();
    if (tri_count > 0 && $urandom_range(0, 3) != 0)
      send_query(8'($urandom_range(0, tri_count - 1)));
    else
      send_query(8'($urandom_range(0, 255)));
  endtask

  // One item of the random mix: mostly loads and queries, now and then a
  // clear, which also moves the vertex pool, or the unused command.
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_mesh_load();
    end else if (pick < 94) begin
      send_random_query();
    end else if (pick < 96) begin
      send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      pool_base = 16'($urandom_range(0, 65528));
    end else begin
      send_item(CmdUnused, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // Stops offering items and waits until every expected result has come,
  // then lets the clock run on with the input idle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_adjacency.size() != 0) @(posedge clk_i);
    repeat (MaxTriangles + 16) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Hand-picked items: empty-table query, shared edges in both orientations,
  // an edge that is already linked, degenerate edges, one stored edge
  // matching several new edges, extreme vertex values, the first index past
  // the loaded ones, the highest index, the unused command and a clear.
  task automatic test_directed();
    send_query(8'd0);
    send_load(16'd0, 16'd1, 16'd2);
    send_load(16'd2, 16'd1, 16'd3);
    send_load(16'd0, 16'd2, 16'd4);
    send_load(16'd1, 16'd0, 16'd5);
    send_load(16'd0, 16'd1, 16'd6);
    send_load(16'd7, 16'd7, 16'd8);
    send_load(16'd7, 16'd7, 16'd9);
    send_load(16'd8, 16'd7, 16'd7);
    send_load(16'hFFFF, 16'h0000, 16'hFFFF);
    send_load(16'h0000, 16'hFFFF, 16'h8000);
    send_load(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_query(8'd0);
    send_query(8'd1);
    send_query(8'd6);
    send_query(8'd10);
    send_query(8'd11);
    send_query(8'd255);
    send_item(CmdUnused, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_item(CMD_CLEAR, 16'h0000, 16'h0000, 16'h0000, 8'h00);
    send_query(8'd0);
    send_load(16'd0, 16'd1, 16'd2);
  endtask

  // Loads a mesh until the table is full, with queries spread in, then
  // tries loads that must be dropped and queries at both ends of the table.
  task automatic test_fill_table();
    send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    pool_base = 16'($urandom_range(0, 65528));
    while (tri_count < MaxTriangles) begin
      send_mesh_load();
      if ($urandom_range(0, 3) == 0) send_random_query();
    end
    repeat (3) send_mesh_load();
    send_query(8'd255);
    send_query(8'd0);
    send_query(8'd128);
    repeat (3) send_random_query();
  endtask

  // Holds the result channel off for a long stretch while items keep coming,
  // so the block backs up and stalls its input.
  task automatic test_backpressure();
    send_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    hold_request = 400;
    repeat (8) send_random_item();
  endtask

  task automatic test_random_mix();
    repeat (620) send_random_item();
  endtask

  // Last stretch with both sides always ready.
  task automatic test_calm_tail();
    calm = 1'b1;
    repeat (60) send_random_item();
  endtask

  initial begin
    failures     = 0;
    calm         = 1'b0;
    hold_request = 0;
    tri_count    = 0;
    pool_base    = 16'd0;
    for (int k = 0; k < 3 * MaxTriangles; k++) begin
      corner_mem[k] = '0;
      link_ok[k]    = 1'b0;
      link_to[k]    = '0;
    end
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.command     <= CMD_LOAD;
    in_if.vertex_a    <= '0;
    in_if.vertex_b    <= '0;
    in_if.vertex_c    <= '0;
    in_if.query_index <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_fill_table();
    test_backpressure();
    test_random_mix();
    test_calm_tail();
    wait_drained();

    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
